// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the attitude-matrix-to-quaternion pipeline.
// Depends on nothing; rotation_matrix_to_quaternion refers to it by scoped names.
package rmq_pkg;

   localparam int ELEM_W     = 32;
   localparam int TRACE_W    = 34;
   localparam int DIFF_W     = 33;
   localparam int U_W        = 33;
   localparam int FRAC1      = 28;
   localparam int FRAC2      = 30;
   localparam int ROOT1_IN_W = 62;
   localparam int P_W        = ROOT1_IN_W / 2 + 1;
   localparam int QUO_W      = 33;
   localparam int Q_W        = QUO_W + 1;
   localparam int MAG_W      = 33;
   localparam int NUM1_W     = MAG_W + FRAC1;
   localparam int NUM2_W     = MAG_W + FRAC2;
   localparam int SQ_W       = 64;
   localparam int ROOT2_IN_W = 64;
   localparam int N_W        = ROOT2_IN_W / 2 + 1;

   localparam logic [U_W-1:0] U_ONE = U_W'(1) << 30;
   localparam logic [P_W-1:0] P_MIN = P_W'(1) << 29;
   localparam logic [N_W-1:0] N_MIN = N_W'(1) << 29;

   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic signed [Q_W-1:0] Q_OUT_MAX =
      {{(Q_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_OUT_MIN =
      {{(Q_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      PIV_S = 2'd0,
      PIV_X = 2'd1,
      PIV_Y = 2'd2,
      PIV_Z = 2'd3
   } pivot_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] m00;
      logic signed [ELEM_W-1:0] m01;
      logic signed [ELEM_W-1:0] m02;
      logic signed [ELEM_W-1:0] m10;
      logic signed [ELEM_W-1:0] m11;
      logic signed [ELEM_W-1:0] m12;
      logic signed [ELEM_W-1:0] m20;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
   } matrix_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] q_scalar;
      logic signed [ELEM_W-1:0] q_x;
      logic signed [ELEM_W-1:0] q_y;
      logic signed [ELEM_W-1:0] q_z;
   } quat_type;

   typedef struct packed {
      pivot_type                pivot;
      logic signed [DIFF_W-1:0] d0;
      logic signed [DIFF_W-1:0] d1;
      logic signed [DIFF_W-1:0] d2;
   } diff_side_type;

   typedef struct packed {
      pivot_type      pivot;
      logic [P_W-1:0] p;
   } pivot_side_type;

endpackage

// ===== design/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined square root rounded to nearest, one result bit per stage.
// Depends on nothing; the bit stages are followed by a registered rounding step.
module rmq_sqrt #(
   parameter int IN_W = 62
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   x,
   output logic [IN_W/2:0]   root
);

   localparam int RT_W = IN_W / 2;

   logic [IN_W-1:0] rem_ff  [RT_W];
   logic [RT_W-1:0] root_ff [RT_W];
   logic [IN_W-1:0] rem_in  [RT_W];
   logic [RT_W-1:0] root_in [RT_W];
   logic [RT_W:0]   out_ff;
   logic [RT_W:0]   out_in;

   always_comb begin
      logic [IN_W-1:0] rem_prev;
      logic [IN_W-1:0] trial;
      logic [RT_W-1:0] root_prev;
      for (int i = 0; i < RT_W; i++) begin
         rem_prev  = (i == 0) ? x : rem_ff[(i == 0) ? 0 : i - 1];
         root_prev = (i == 0) ? '0 : root_ff[(i == 0) ? 0 : i - 1];
         trial     = (IN_W'(root_prev) << (RT_W - i)) | (IN_W'(1) << (2 * (RT_W - 1 - i)));
         if (rem_prev >= trial) begin
            rem_in[i]  = rem_prev - trial;
            root_in[i] = root_prev | (RT_W'(1) << (RT_W - 1 - i));
         end else begin
            rem_in[i]  = rem_prev;
            root_in[i] = root_prev;
         end
      end
      out_in = (RT_W + 1)'(root_ff[RT_W-1])
             + (RT_W + 1)'(rem_ff[RT_W-1] > IN_W'(root_ff[RT_W-1]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < RT_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign root = out_ff;

endmodule

// ===== design/rmq_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed-magnitude divider rounded half away from zero.
// Depends on nothing; one quotient bit per stage, after a registered rounding bias.
module rmq_div #(
   parameter int NUM_W = 61,
   parameter int DEN_W = 32,
   parameter int QUO_W = 33
) (
   input  logic                clock,
   input  logic                en,
   input  logic                neg,
   input  logic [NUM_W-1:0]    mag,
   input  logic [DEN_W-1:0]    den,
   output logic signed [QUO_W:0] quo
);

   localparam int CMP_W = DEN_W + QUO_W;

   logic [CMP_W-1:0] bias_ff;
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic [CMP_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [CMP_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [CMP_W-1:0] rem_prev;
      logic [CMP_W-1:0] trial;
      logic [QUO_W-1:0] quo_prev;
      for (int i = 0; i < QUO_W; i++) begin
         rem_prev = (i == 0) ? bias_ff : rem_ff[(i == 0) ? 0 : i - 1];
         quo_prev = (i == 0) ? '0 : quo_ff[(i == 0) ? 0 : i - 1];
         trial    = CMP_W'(den_ff[i]) << (QUO_W - 1 - i);
         if (rem_prev >= trial) begin
            rem_in[i] = rem_prev - trial;
            quo_in[i] = quo_prev | (QUO_W'(1) << (QUO_W - 1 - i));
         end else begin
            rem_in[i] = rem_prev;
            quo_in[i] = quo_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bias_ff   <= CMP_W'(mag) + CMP_W'(den >> 1);
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         for (int i = 0; i < QUO_W; i++) begin
            rem_ff[i]   <= rem_in[i];
            quo_ff[i]   <= quo_in[i];
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign quo = neg_ff[QUO_W] ? -$signed({1'b0, quo_ff[QUO_W-1]})
                              : $signed({1'b0, quo_ff[QUO_W-1]});

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// Attitude matrix to unit quaternion, pivot on the largest trace, Q2.30.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//   channel | ports                       | beat
//   req     | req_valid req_stall req_data | one 3x3 matrix
//   rsp     | rsp_valid rsp_stall rsp_data | one quaternion
//
// One beat in per cycle while not stalled; the pipeline depth is set by two square-root
// pipelines and two divider pipelines of one result bit per stage.
// Reset clears only the valid bits. A stalled result halts the pipeline only
// when its last stage is also full, so bubbles drain into the output register.
module rotation_matrix_to_quaternion (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rmq_pkg::matrix_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rmq_pkg::quat_type   rsp_data
);

   localparam int TW  = rmq_pkg::TRACE_W;
   localparam int DW  = rmq_pkg::DIFF_W;
   localparam int QW  = rmq_pkg::Q_W;
   localparam int MW  = rmq_pkg::MAG_W;
   localparam int L1  = rmq_pkg::ROOT1_IN_W / 2 + 1;
   localparam int LD1 = rmq_pkg::QUO_W + 1;
   localparam int L2  = rmq_pkg::ROOT2_IN_W / 2 + 1;
   localparam int LD2 = rmq_pkg::QUO_W + 1;
   localparam int IX_B    = 1;
   localparam int IX_P    = IX_B + L1;
   localparam int IX_DIV1 = IX_P + LD1;
   localparam int IX_F    = IX_DIV1 + 4;
   localparam int IX_N    = IX_F + L2;
   localparam int IX_G    = IX_N + LD2 + 1;
   localparam int TOTAL   = IX_G + 1;

   logic             en;
   logic             rsp_load;
   logic             rsp_valid_ff;
   logic [TOTAL-1:0] vld_ff;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = !vld_ff[IX_G] || rsp_load;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_valid};
      end
   end

   // traces
   rmq_pkg::matrix_type     a_mat_ff;
   logic signed [TW-1:0]    t_ff [4];
   logic signed [TW-1:0]    t_in [4];

   always_comb begin
      logic signed [TW-1:0] e00;
      logic signed [TW-1:0] e11;
      logic signed [TW-1:0] e22;
      e00 = TW'(req_data.m00);
      e11 = TW'(req_data.m11);
      e22 = TW'(req_data.m22);
      t_in[0] =  e00 + e11 + e22;
      t_in[1] =  e00 - e11 - e22;
      t_in[2] = -e00 + e11 - e22;
      t_in[3] = -e00 - e11 + e22;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mat_ff <= req_data;
         for (int k = 0; k < 4; k++) t_ff[k] <= t_in[k];
      end
   end

   // pivot and off-diagonal terms
   rmq_pkg::diff_side_type          b_ff;
   rmq_pkg::diff_side_type          b_in;
   logic [rmq_pkg::U_W-1:0]         u_ff;
   logic [rmq_pkg::U_W-1:0]         u_in;

   always_comb begin
      logic signed [DW-1:0] d12, d20, d01, s01, s20, s12;
      logic signed [TW-1:0] tp;
      d12 = DW'(a_mat_ff.m12) - DW'(a_mat_ff.m21);
      d20 = DW'(a_mat_ff.m20) - DW'(a_mat_ff.m02);
      d01 = DW'(a_mat_ff.m01) - DW'(a_mat_ff.m10);
      s01 = DW'(a_mat_ff.m01) + DW'(a_mat_ff.m10);
      s20 = DW'(a_mat_ff.m20) + DW'(a_mat_ff.m02);
      s12 = DW'(a_mat_ff.m12) + DW'(a_mat_ff.m21);
      if (t_ff[0] >= t_ff[1] && t_ff[0] >= t_ff[2] && t_ff[0] >= t_ff[3]) begin
         tp = t_ff[0];
         b_in = '{pivot: rmq_pkg::PIV_S, d0: d12, d1: d20, d2: d01};
      end else if (t_ff[1] >= t_ff[2] && t_ff[1] >= t_ff[3]) begin
         tp = t_ff[1];
         b_in = '{pivot: rmq_pkg::PIV_X, d0: d12, d1: s01, d2: s20};
      end else if (t_ff[2] >= t_ff[3]) begin
         tp = t_ff[2];
         b_in = '{pivot: rmq_pkg::PIV_Y, d0: d20, d1: s01, d2: s12};
      end else begin
         tp = t_ff[3];
         b_in = '{pivot: rmq_pkg::PIV_Z, d0: d01, d1: s20, d2: s12};
      end
      u_in = rmq_pkg::U_ONE + rmq_pkg::U_W'(tp);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff <= b_in;
         u_ff <= u_in;
      end
   end

   // pivot component
   logic [rmq_pkg::P_W-1:0]  p_root;
   rmq_pkg::diff_side_type   seg1_ff [L1];

   rmq_sqrt #(
      .IN_W (rmq_pkg::ROOT1_IN_W)
   ) u_sqrt_pivot (
      .clock (clock),
      .en    (en),
      .x     (rmq_pkg::ROOT1_IN_W'({u_ff, {rmq_pkg::FRAC1{1'b0}}})),
      .root  (p_root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         seg1_ff[0] <= b_ff;
         for (int k = 1; k < L1; k++) seg1_ff[k] <= seg1_ff[k-1];
      end
   end

   // remaining components
   logic signed [DW-1:0]      d_arr [3];
   logic signed [QW-1:0]      quo1  [3];
   rmq_pkg::pivot_side_type   seg2_ff [LD1];

   assign d_arr[0] = seg1_ff[L1-1].d0;
   assign d_arr[1] = seg1_ff[L1-1].d1;
   assign d_arr[2] = seg1_ff[L1-1].d2;

   for (genvar j = 0; j < 3; j++) begin : g_div_comp
      logic [MW-1:0] mag;
      assign mag = d_arr[j][DW-1] ? MW'(-d_arr[j]) : MW'(d_arr[j]);
      rmq_div #(
         .NUM_W (rmq_pkg::NUM1_W),
         .DEN_W (rmq_pkg::P_W),
         .QUO_W (rmq_pkg::QUO_W)
      ) u_div (
         .clock (clock),
         .en    (en),
         .neg   (d_arr[j][DW-1]),
         .mag   ({mag, {rmq_pkg::FRAC1{1'b0}}}),
         .den   (p_root),
         .quo   (quo1[j])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg2_ff[0] <= '{pivot: seg1_ff[L1-1].pivot, p: p_root};
         for (int k = 1; k < LD1; k++) seg2_ff[k] <= seg2_ff[k-1];
      end
   end

   // assemble, square, sum
   logic signed [QW-1:0]          qc_ff [4];
   logic signed [QW-1:0]          qc_in [4];
   logic signed [QW-1:0]          qd_ff [4];
   logic signed [QW-1:0]          qe_ff [4];
   logic signed [QW-1:0]          qf_ff [4];
   logic [rmq_pkg::SQ_W-1:0]      sq_ff [4];
   logic [rmq_pkg::SQ_W-1:0]      sq_in [4];
   logic [rmq_pkg::SQ_W-1:0]      s01_ff;
   logic [rmq_pkg::SQ_W-1:0]      s23_ff;
   logic [rmq_pkg::SQ_W-1:0]      nn_ff;

   always_comb begin
      logic signed [QW-1:0] pv;
      pv = QW'(seg2_ff[LD1-1].p);
      unique case (seg2_ff[LD1-1].pivot)
         rmq_pkg::PIV_S: qc_in = '{pv, quo1[0], quo1[1], quo1[2]};
         rmq_pkg::PIV_X: qc_in = '{quo1[0], pv, quo1[1], quo1[2]};
         rmq_pkg::PIV_Y: qc_in = '{quo1[0], quo1[1], pv, quo1[2]};
         rmq_pkg::PIV_Z: qc_in = '{quo1[0], quo1[1], quo1[2], pv};
         default:        qc_in = '{pv, quo1[0], quo1[1], quo1[2]};
      endcase
   end

   always_comb begin
      logic [MW-1:0]   mag;
      logic [2*MW-1:0] prod;
      for (int k = 0; k < 4; k++) begin
         mag      = qc_ff[k][QW-1] ? MW'(-qc_ff[k]) : MW'(qc_ff[k]);
         prod     = (2 * MW)'(mag) * (2 * MW)'(mag);
         sq_in[k] = prod[rmq_pkg::SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            qc_ff[k] <= qc_in[k];
            qd_ff[k] <= qc_ff[k];
            qe_ff[k] <= qd_ff[k];
            qf_ff[k] <= qe_ff[k];
            sq_ff[k] <= sq_in[k];
         end
         s01_ff <= sq_ff[0] + sq_ff[1];
         s23_ff <= sq_ff[2] + sq_ff[3];
         nn_ff  <= s01_ff + s23_ff;
      end
   end

   // norm and normalisation
   logic [rmq_pkg::N_W-1:0] n_root;
   logic signed [QW-1:0]    seg3_ff [L2][4];
   logic signed [QW-1:0]    quo2    [4];

   rmq_sqrt #(
      .IN_W (rmq_pkg::ROOT2_IN_W)
   ) u_sqrt_norm (
      .clock (clock),
      .en    (en),
      .x     (nn_ff),
      .root  (n_root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         seg3_ff[0] <= qf_ff;
         for (int k = 1; k < L2; k++) seg3_ff[k] <= seg3_ff[k-1];
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_div_norm
      logic [MW-1:0] mag;
      assign mag = seg3_ff[L2-1][j][QW-1] ? MW'(-seg3_ff[L2-1][j]) : MW'(seg3_ff[L2-1][j]);
      rmq_div #(
         .NUM_W (rmq_pkg::NUM2_W),
         .DEN_W (rmq_pkg::N_W),
         .QUO_W (rmq_pkg::QUO_W)
      ) u_div (
         .clock (clock),
         .en    (en),
         .neg   (seg3_ff[L2-1][j][QW-1]),
         .mag   ({mag, {rmq_pkg::FRAC2{1'b0}}}),
         .den   (n_root),
         .quo   (quo2[j])
      );
   end

   // saturate, fix sign, output register
   rmq_pkg::quat_type g_ff;
   rmq_pkg::quat_type g_in;
   rmq_pkg::quat_type rsp_data_ff;

   always_comb begin
      logic signed [rmq_pkg::ELEM_W-1:0] sat [4];
      for (int k = 0; k < 4; k++) begin
         if (quo2[k] > rmq_pkg::Q_OUT_MAX) begin
            sat[k] = rmq_pkg::ELEM_MAX;
         end else if (quo2[k] < rmq_pkg::Q_OUT_MIN) begin
            sat[k] = rmq_pkg::ELEM_MIN;
         end else begin
            sat[k] = quo2[k][rmq_pkg::ELEM_W-1:0];
         end
      end
      if (sat[0] < 0) begin
         for (int k = 0; k < 4; k++) begin
            sat[k] = (sat[k] == rmq_pkg::ELEM_MIN) ? rmq_pkg::ELEM_MAX : -sat[k];
         end
      end
      g_in = '{q_scalar: sat[0], q_x: sat[1], q_y: sat[2], q_z: sat[3]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff <= g_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= vld_ff[IX_G];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && vld_ff[IX_G]) begin
         rsp_data_ff <= g_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the output side can drain");

   a_scalar_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.q_scalar[rmq_pkg::ELEM_W-1])
      else $error("negative scalar part on result beat");

   a_pivot_radicand: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IX_B] |-> u_ff >= rmq_pkg::U_ONE)
      else $error("pivot trace below zero");

   a_pivot_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IX_P] |-> p_root >= rmq_pkg::P_MIN)
      else $error("pivot component below one half");

   a_norm_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[IX_N] |-> n_root >= rmq_pkg::N_MIN)
      else $error("norm below one half");
`endif

endmodule
